// ----- rtl/mlp121_pkg.sv -----
package mlp121_pkg;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = 28;
  localparam int unsigned MUL_P_W = 63;

  // tanh span index taken from the product, and its fraction
  localparam int unsigned SPAN_IDX_W = 18;
  localparam int unsigned SPAN_REM_W = 22;
  localparam int unsigned TANH_W     = 17;

  localparam logic signed [MUL_P_W-1:0] ONE_SQ_Q32 = 63'sd4294967296;

  // operation codes carried on tuser
  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic REG_LEARNING_RATE   = 1'b0;
  localparam logic REG_ERROR_THRESHOLD = 1'b1;

  localparam logic [2:0] NUM_WEIGHTS = 3'd7;

  // control states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } ctrl_state_t;

  // sequencer steps: each issues at most one product and retires the previous one, if any
  typedef enum logic [4:0] {
    SQ_HID0, SQ_HID1, SQ_SPAN0, SQ_SPAN1, SQ_INTERP0, SQ_INTERP1,
    SQ_OUT0, SQ_OUT1, SQ_OUT_SUM, SQ_SLOPE0, SQ_ERR_SQ, SQ_SLOPE1,
    SQ_CHECK, SQ_BACK0, SQ_BACK1, SQ_DELTA0, SQ_DELTA1, SQ_GRAD4,
    SQ_GRAD5, SQ_UPD4, SQ_UPD5, SQ_UPD6, SQ_GRAD0, SQ_GRAD2,
    SQ_UPD0, SQ_UPD1, SQ_UPD2, SQ_UPD3
  } seq_step_t;

  // round half up, then arithmetic shift
  function automatic logic signed [MUL_P_W-1:0] rnd_shift(
    input logic signed [MUL_P_W-1:0] v,
    input int unsigned n
  );
    logic signed [MUL_P_W-1:0] half;
    half = 63'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic [23:0] sat24(input logic signed [MUL_P_W-1:0] v);
    logic [23:0] r;
    if (v > 63'sd8388607) r = 24'h7fffff;
    else if (v < -63'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [MUL_P_W-1:0] v);
    logic [15:0] r;
    if (v > 63'sd32767) r = 16'h7fff;
    else if (v < -63'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  // pade [7/6] tanh in Q16, evaluated at elaboration for the table
  function automatic logic [TANH_W-1:0] pade_tanh(input logic [63:0] a);
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] num;
    s = (a * a) >> 16;
    n = s;
    d = 64'd28 * s;
    n = ((n + (64'd378 << 16)) * s) >> 16;
    n = ((n + (64'd17325 << 16)) * s) >> 16;
    n = n + (64'd135135 << 16);
    n = (n * a) >> 16;
    d = ((d + (64'd3150 << 16)) * s) >> 16;
    d = ((d + (64'd62370 << 16)) * s) >> 16;
    d = d + (64'd135135 << 16);
    // long division of the scaled numerator, one quotient bit per pass
    num = n << 16;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return (q > 64'd65536) ? 17'd65536 : q[TANH_W-1:0];
  endfunction

endpackage

// ----- rtl/mlp121_mul.sv -----
module mlp121_mul
  import mlp121_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  // registered signed product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/mlp121_tanh_rom.sv -----
module mlp121_tanh_rom
  import mlp121_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic [SPAN_IDX_W-1:0] addr,
  output logic [TANH_W-1:0]     base,
  output logic [TANH_W-1:0]     diff
);

  localparam int unsigned IW = $clog2(DEPTH + 1);

  logic [TANH_W-1:0] tab [0:DEPTH];
  logic [IW-1:0]     lo;
  logic [IW-1:0]     lo_nx;

  // table over [0,4], kept non-decreasing
  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam logic [63:0] A_K = (64'(k) * 64'd262144) / 64'(DEPTH);
    localparam logic [TANH_W-1:0] P_K = pade_tanh(A_K);
    if (k == 0) begin : g_first
      assign tab[k] = P_K;
    end else begin : g_rest
      assign tab[k] = (P_K < tab[k-1]) ? tab[k-1] : P_K;
    end
  end

  assign lo    = addr[IW-1:0];
  assign lo_nx = lo + IW'(1);

  // entry and slope to the next entry, flat past the end
  always_comb begin
    if (addr >= SPAN_IDX_W'(DEPTH)) begin
      base = tab[DEPTH];
      diff = '0;
    end else begin
      base = tab[lo];
      diff = tab[lo_nx] - tab[lo];
    end
  end

endmodule

// ----- rtl/mlp121_seq.sv -----
module mlp121_seq
  import mlp121_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                op,
  input  logic signed [15:0]        x_value,
  input  logic signed [15:0]        y_target,
  input  logic [2:0]                weight_index,
  input  logic [23:0]               weight_value,
  input  logic [15:0]               learning_rate,
  input  logic [23:0]               error_threshold,
  output logic                      busy,
  output logic                      done,
  output logic [15:0]               prediction,
  output logic                      converged,
  output logic [6:0][23:0]          weights
);

  ctrl_state_t state;
  seq_step_t   step;
  logic        is_train;

  logic signed [15:0] x_q;
  logic signed [15:0] y_q;

  logic signed [27:0] s0, s1;
  logic [SPAN_IDX_W-1:0] idx0, idx1;
  logic [SPAN_REM_W-1:0] rem0, rem1;
  logic [TANH_W-1:0]     tbase;
  logic signed [17:0]    h0, h1;
  logic signed [26:0]    o;
  logic signed [26:0]    e;
  logic [16:0]           g0, g1;
  logic signed [27:0]    t0, t1;
  logic signed [30:0]    d0, d1;
  logic signed [33:0]    ga, gb;

  logic signed [27:0]    d_val;
  logic [27:0]           mag0, mag1;
  logic [TANH_W-1:0]     r_val;
  logic signed [26:0]    o_sum;

  logic [SPAN_IDX_W-1:0] rom_addr;
  logic [TANH_W-1:0]     rom_base;
  logic [TANH_W-1:0]     rom_diff;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] p;

  mlp121_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  mlp121_tanh_rom #(
    .DEPTH (DEPTH)
  ) u_rom (
    .addr (rom_addr),
    .base (rom_base),
    .diff (rom_diff)
  );

  assign busy  = (state != S_IDLE);
  assign done  = (state == S_FIN);
  assign d_val = -(28'(e) <<< 1);
  assign mag0  = s0[27] ? 28'(-s0) : 28'(s0);
  assign mag1  = s1[27] ? 28'(-s1) : 28'(s1);
  assign r_val = tbase + p[38:22];
  assign o_sum = o + 27'(rnd_shift(p, 16));
  assign rom_addr = (step == SQ_INTERP0) ? idx0 : idx1;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      SQ_HID0:    begin mul_a = 35'(x_q);   mul_b = 28'($signed(weights[0])); end
      SQ_HID1:    begin mul_a = 35'(x_q);   mul_b = 28'($signed(weights[2])); end
      SQ_SPAN0:   begin mul_a = 35'(mag0);  mul_b = 28'(DEPTH); end
      SQ_SPAN1:   begin mul_a = 35'(mag1);  mul_b = 28'(DEPTH); end
      SQ_INTERP0: begin mul_a = 35'(rem0);  mul_b = 28'(rom_diff); end
      SQ_INTERP1: begin mul_a = 35'(rem1);  mul_b = 28'(rom_diff); end
      SQ_OUT0:    begin mul_a = 35'($signed(weights[4])); mul_b = 28'(h0); end
      SQ_OUT1:    begin mul_a = 35'($signed(weights[5])); mul_b = 28'(h1); end
      SQ_SLOPE0:  begin mul_a = 35'(h0);    mul_b = 28'(h0); end
      SQ_ERR_SQ:  begin mul_a = 35'(e);     mul_b = 28'(e); end
      SQ_SLOPE1:  begin mul_a = 35'(h1);    mul_b = 28'(h1); end
      SQ_CHECK:   begin mul_a = 35'(d_val); mul_b = 28'(g0); end
      SQ_BACK0:   begin mul_a = 35'(d_val); mul_b = 28'(g1); end
      SQ_BACK1:   begin mul_a = 35'(t0);    mul_b = 28'($signed(weights[4])); end
      SQ_DELTA0:  begin mul_a = 35'(t1);    mul_b = 28'($signed(weights[5])); end
      SQ_DELTA1:  begin mul_a = 35'(d_val); mul_b = 28'(h0); end
      SQ_GRAD4:   begin mul_a = 35'(d_val); mul_b = 28'(h1); end
      SQ_GRAD5:   begin mul_a = 35'(ga);    mul_b = 28'(learning_rate); end
      SQ_UPD4:    begin mul_a = 35'(gb);    mul_b = 28'(learning_rate); end
      SQ_UPD5:    begin mul_a = 35'(d_val); mul_b = 28'(learning_rate); end
      SQ_UPD6:    begin mul_a = 35'(d0);    mul_b = 28'(x_q); end
      SQ_GRAD0:   begin mul_a = 35'(d1);    mul_b = 28'(x_q); end
      SQ_GRAD2:   begin mul_a = 35'(ga);    mul_b = 28'(learning_rate); end
      SQ_UPD0:    begin mul_a = 35'(d0);    mul_b = 28'(learning_rate); end
      SQ_UPD1:    begin mul_a = 35'(gb);    mul_b = 28'(learning_rate); end
      SQ_UPD2:    begin mul_a = 35'(d1);    mul_b = 28'(learning_rate); end
      default:    begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // control: state and step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= SQ_HID0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            step <= SQ_HID0;
            if (op == OP_PREDICT || op == OP_TRAIN) state <= S_RUN;
            else state <= S_FIN;
          end
        end
        S_RUN: begin
          step <= seq_step_t'(step + 5'd1);
          if ((step == SQ_OUT_SUM && !is_train) || (step == SQ_CHECK && converged) ||
              step == SQ_UPD3) begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // weight file: reset clear, direct write, and sgd updates
  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= '0;
    end else if (state == S_IDLE && start) begin
      if (op == OP_WRITE && weight_index < NUM_WEIGHTS) begin
        weights[weight_index] <= weight_value;
      end
    end else if (state == S_RUN) begin
      case (step)
        SQ_UPD4: weights[4] <= sat24(63'($signed(weights[4])) - rnd_shift(p, 16));
        SQ_UPD5: weights[5] <= sat24(63'($signed(weights[5])) - rnd_shift(p, 16));
        SQ_UPD6: weights[6] <= sat24(63'($signed(weights[6])) - rnd_shift(p, 16));
        SQ_UPD0: weights[0] <= sat24(63'($signed(weights[0])) - rnd_shift(p, 16));
        SQ_UPD1: weights[1] <= sat24(63'($signed(weights[1])) - rnd_shift(p, 16));
        SQ_UPD2: weights[2] <= sat24(63'($signed(weights[2])) - rnd_shift(p, 16));
        SQ_UPD3: weights[3] <= sat24(63'($signed(weights[3])) - rnd_shift(p, 16));
        default: weights <= weights;
      endcase
    end
  end

  // datapath: retire the product issued one step earlier
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      is_train   <= (op == OP_TRAIN);
      x_q        <= x_value;
      y_q        <= y_target;
      prediction <= '0;
      converged  <= 1'b0;
    end else if (state == S_RUN) begin
      case (step)
        SQ_HID1:    s0 <= 28'(rnd_shift(p, 12)) + 28'($signed(weights[1]));
        SQ_SPAN0:   s1 <= 28'(rnd_shift(p, 12)) + 28'($signed(weights[3]));
        SQ_SPAN1:   begin idx0 <= p[39:22]; rem0 <= p[21:0]; end
        SQ_INTERP0: begin idx1 <= p[39:22]; rem1 <= p[21:0]; tbase <= rom_base; end
        SQ_INTERP1: begin
          h0    <= s0[27] ? -18'(r_val) : 18'(r_val);
          tbase <= rom_base;
        end
        SQ_OUT0:    h1 <= s1[27] ? -18'(r_val) : 18'(r_val);
        SQ_OUT1:    o  <= 27'(rnd_shift(p, 16)) + 27'($signed(weights[6]));
        SQ_OUT_SUM: begin
          o          <= o_sum;
          prediction <= sat16(rnd_shift(63'(o_sum), 8));
        end
        SQ_SLOPE0:  e  <= 27'($signed({y_q, 8'd0})) - o;
        SQ_ERR_SQ:  g0 <= 17'(rnd_shift(ONE_SQ_Q32 - p, 16));
        SQ_SLOPE1:  converged <= (rnd_shift(p, 16) <= $signed(63'(error_threshold)));
        SQ_CHECK:   g1 <= 17'(rnd_shift(ONE_SQ_Q32 - p, 16));
        SQ_BACK0:   t0 <= 28'(rnd_shift(p, 16));
        SQ_BACK1:   t1 <= 28'(rnd_shift(p, 16));
        SQ_DELTA0:  d0 <= 31'(rnd_shift(p, 20));
        SQ_DELTA1:  d1 <= 31'(rnd_shift(p, 20));
        SQ_GRAD4:   ga <= 34'(rnd_shift(p, 16));
        SQ_GRAD5:   gb <= 34'(rnd_shift(p, 16));
        SQ_GRAD0:   ga <= 34'(rnd_shift(p, 12));
        SQ_GRAD2:   gb <= 34'(rnd_shift(p, 12));
        default:    o  <= o;
      endcase
    end
  end

endmodule

// ----- rtl/mlp_1_2_1_sgd_trainer_core.sv -----
// 1-2-1 tanh network trainer, fixed point, one shared multiplier.
// Input stream: s_tuser carries the operation (predict, train, write weight),
// s_tdata the network input, target, weight index and weight value.
// Output stream: one transfer per input item with the prediction and the
// converged flag. Configuration channel: cfg_index 0 learning rate,
// 1 error threshold; writes are taken in any cycle and belong to idle time.
// Predict ends after the forward pass; train ends after the error check
// when the error is at or below the threshold, else after the weight
// update; a weight write or unused op finishes without running. s_tready
// rises in the same cycle as m_tvalid, so one item is taken at a time,
// with the sequencer issuing one product per cycle on the multiplier.
// Reset clears all weights, loads the default learning rate and threshold
// and empties the output register. When the receiver stalls the finished
// result is held back until the output register frees, and no item is
// accepted in that time.
module mlp_1_2_1_sgd_trainer_core
  import mlp121_pkg::*;
#(
  parameter int unsigned TANH_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // x_value, y_target, weight_index, weight_value
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // prediction, converged
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  logic [15:0]       learning_rate;
  logic [23:0]       error_threshold;
  logic              busy;
  logic              done_raw;
  logic              hold;
  logic [15:0]       prediction;
  logic              converged;
  logic [6:0][23:0]  weights;
  logic              start;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !busy && !hold;
  assign start     = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= 16'd6554;
      error_threshold <= 24'd17;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LEARNING_RATE) learning_rate <= cfg_data[15:0];
      else if (cfg_index == REG_ERROR_THRESHOLD) error_threshold <= cfg_data;
    end
  end

  mlp121_seq #(
    .DEPTH (TANH_TABLE_DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .op              (s_tuser),
    .x_value         (s_tdata[15:0]),
    .y_target        (s_tdata[31:16]),
    .weight_index    (s_tdata[34:32]),
    .weight_value    (s_tdata[58:35]),
    .learning_rate   (learning_rate),
    .error_threshold (error_threshold),
    .busy            (busy),
    .done            (done_raw),
    .prediction      (prediction),
    .converged       (converged),
    .weights         (weights)
  );

  // result register; the finished item waits here while the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      hold     <= 1'b0;
    end else begin
      if ((done_raw || hold) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'd0, converged, prediction};
        hold     <= 1'b0;
      end else begin
        if (m_tvalid && m_tready) m_tvalid <= 1'b0;
        if (done_raw) hold <= 1'b1;
      end
    end
  end

  // no new item while a result is held back
  property p_no_accept_while_held;
    @(posedge clk) disable iff (rst) hold |-> !start;
  endproperty

  a_run_not_ready: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input accepted while sequencer busy");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (done_raw && out_free) |=> m_tvalid)
    else $error("finished item not presented");

  a_weights_quiet: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(weights))
    else $error("weights changed while idle");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (hold && !out_free) |=> (hold || m_tvalid))
    else $error("held result lost");

  a_no_accept_held: assert property (p_no_accept_while_held)
    else $error("input accepted while result held");

endmodule

// ----- tb/sv/mlp_1_2_1_sgd_trainer_core_test.sv -----
`timescale 1ns / 1ps

module mlp_1_2_1_sgd_trainer_core_test;
  import mlp121_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam longint unsigned SPAN_Q20 = 64'd4 << 20;
  localparam longint unsigned UNIT_Q16 = 64'd65536;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [15:0] prediction;
    logic        converged;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_PREDICT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_LEARNING_RATE;
  logic [23:0] cfg_data = '0;

  // network state mirrored by the testbench
  longint          net_w[7];
  longint unsigned step_rate;
  longint unsigned err_limit;
  longint unsigned tanh_lut[TABLE_DEPTH+1];

  outcome_t pending[$];
  int       errors = 0;
  int       cycles = 0;
  int       stall_pct = 0;
  int       gap_max = 0;
  int       burst_left = 0;

  mlp_1_2_1_sgd_trainer_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // fixed-point helpers
  function automatic longint rnd(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(input longint v, input int w);
    longint lim;
    lim = 64'sd1 <<< (w - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // rational tanh approximation in Q16
  function automatic longint unsigned rational_tanh(input longint unsigned a);
    longint unsigned s, n, d;
    s = (a * a) >> 16;
    n = s;
    d = 64'd28 * s;
    n = ((n + (64'd378 << 16)) * s) >> 16;
    n = ((n + (64'd17325 << 16)) * s) >> 16;
    n = n + (64'd135135 << 16);
    n = (n * a) >> 16;
    d = ((d + (64'd3150 << 16)) * s) >> 16;
    d = ((d + (64'd62370 << 16)) * s) >> 16;
    d = d + (64'd135135 << 16);
    n = (n << 16) / d;
    return (n > UNIT_Q16) ? UNIT_Q16 : n;
  endfunction

  task automatic build_tanh_lut();
    longint unsigned v;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      v = rational_tanh((64'(k) * 4 * UNIT_Q16) / TABLE_DEPTH);
      if (k > 0 && v < tanh_lut[k-1]) v = tanh_lut[k-1];
      tanh_lut[k] = v;
    end
  endtask

  function automatic longint hidden_tanh(input longint s);
    longint unsigned mag, p, i, r, rem;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    p = mag * TABLE_DEPTH;
    i = p / SPAN_Q20;
    if (i >= TABLE_DEPTH) begin
      r = tanh_lut[TABLE_DEPTH];
    end else begin
      rem = p % SPAN_Q20;
      r = tanh_lut[i] + ((tanh_lut[i+1] - tanh_lut[i]) * rem) / SPAN_Q20;
    end
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void sgd_update(input int k, input longint grad);
    net_w[k] = clip(net_w[k] - rnd(grad * longint'(step_rate), 16), 24);
  endfunction

  // weight write, or forward pass, error check and weight update, for one accepted item
  function automatic outcome_t train_network(input op_t op, input logic [15:0] xr,
                                             input logic [15:0] yr, input logic [2:0] idx,
                                             input logic [23:0] val);
    outcome_t res;
    longint x, y, h0, h1, o, e, d, g0, g1, d0, d1;
    longint unsigned mag, sq;
    res = '0;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    if (op == OP_WRITE) begin
      if (idx < NUM_WEIGHTS) net_w[idx] = longint'($signed(val));
      return res;
    end
    if (op == OP_NONE) return res;
    h0 = hidden_tanh(rnd(x * net_w[0], 12) + net_w[1]);
    h1 = hidden_tanh(rnd(x * net_w[2], 12) + net_w[3]);
    o = rnd(h0 * net_w[4], 16) + rnd(h1 * net_w[5], 16) + net_w[6];
    res.prediction = 16'(clip(rnd(o, 8), 16));
    if (op == OP_PREDICT) return res;
    e = y * 256 - o;
    mag = (e < 0) ? longint'(-e) : longint'(e);
    sq = (mag * mag + (64'd1 << 15)) >> 16;
    res.converged = (sq <= err_limit);
    if (!res.converged) begin
      g0 = rnd(64'sd4294967296 - h0 * h0, 16);
      g1 = rnd(64'sd4294967296 - h1 * h1, 16);
      d = -2 * e;
      d0 = rnd(rnd(g0 * d, 16) * net_w[4], 20);
      d1 = rnd(rnd(g1 * d, 16) * net_w[5], 20);
      sgd_update(4, rnd(d * h0, 16));
      sgd_update(5, rnd(d * h1, 16));
      sgd_update(6, d);
      sgd_update(0, rnd(d0 * x, 12));
      sgd_update(1, d0);
      sgd_update(2, rnd(d1 * x, 12));
      sgd_update(3, d1);
    end
    return res;
  endfunction

  // result receiver stalls on its own random pattern
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pred=%h conv=%b", $time, m_tdata[15:0], m_tdata[16]);
        errors++;
      end else begin
        want = pending.pop_front();
        if (m_tdata[15:0] !== want.prediction) begin
          $display("%0t: prediction expected %h actual %h", $time, want.prediction,
                   m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[16] !== want.converged) begin
          $display("%0t: converged expected %b actual %b", $time, want.converged, m_tdata[16]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("mlp_1_2_1_sgd_trainer_core regression: fail");
      $finish;
    end
  end

  // one input transfer, with bursts and random gaps
  task automatic send_item(input op_t op, input logic [15:0] x, input logic [15:0] y,
                           input logic [2:0] idx, input logic [23:0] val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'd0, val, idx, y, x};
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    pending.push_back(train_network(op, x, y, idx, val));
  endtask

  // idle the input and let every result drain
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == REG_LEARNING_RATE) step_rate = val[15:0];
    else err_limit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    stall_pct = 0;
    gap_max = 0;
    send_item(OP_PREDICT, 16'h7fff, 16'h0, 3'd0, 24'h0);
    send_item(OP_TRAIN, 16'h1000, 16'h0000, 3'd0, 24'h0);
    for (int k = 0; k < 7; k++)
      send_item(OP_WRITE, 16'h0, 16'h0, 3'(k), 24'(($urandom_range(0, 1 << 21)) - (1 << 20)));
    send_item(OP_WRITE, 16'hffff, 16'hffff, 3'd7, 24'hffffff);
    send_item(OP_PREDICT, 16'h7fff, 16'h0, 3'd0, 24'h0);
    send_item(OP_PREDICT, 16'h8000, 16'h0, 3'd0, 24'h0);
    send_item(OP_TRAIN, 16'h0800, 16'h7fff, 3'd0, 24'h0);
    send_item(OP_TRAIN, 16'hf800, 16'h8000, 3'd0, 24'h0);
    send_item(OP_NONE, 16'h1234, 16'h5678, 3'd3, 24'h123456);
    send_item(OP_WRITE, 16'h0, 16'h0, 3'd4, 24'h7fffff);
    send_item(OP_WRITE, 16'h0, 16'h0, 3'd6, 24'h800000);
    send_item(OP_PREDICT, 16'h4000, 16'h0, 3'd0, 24'h0);
    send_item(OP_TRAIN, 16'h7fff, 16'h8000, 3'd0, 24'h0);
    send_item(OP_TRAIN, 16'h8000, 16'h7fff, 3'd0, 24'h0);
    send_item(OP_PREDICT, 16'h0, 16'h0, 3'd0, 24'h0);
    drain();
  endtask

  // well-formed training runs on a smooth target, with periodic weight writes and some noise items
  task automatic test_training(input int items);
    int xi, yi;
    for (int n = 0; n < items; n++) begin
      if (n % 60 == 0) begin
        for (int k = 0; k < 7; k++)
          send_item(OP_WRITE, 16'($urandom), 16'($urandom), 3'(k),
                    24'(($urandom_range(0, 1 << 21)) - (1 << 20)));
      end else if ($urandom_range(99) < 10) begin
        send_item(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  3'($urandom), 24'($urandom));
      end else begin
        xi = $urandom_range(0, 16384) - 8192;
        yi = xi / 2 + $urandom_range(0, 512) - 256;
        send_item(($urandom_range(99) < 80) ? OP_TRAIN : OP_PREDICT, 16'(xi), 16'(yi),
                  3'($urandom), 24'($urandom));
      end
    end
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_LEARNING_RATE, 24'd65535);
    write_reg(REG_ERROR_THRESHOLD, 24'd0);
    stall_pct = 30;
    gap_max = 6;
    test_training(90);
    write_reg(REG_LEARNING_RATE, 24'd0);
    write_reg(REG_ERROR_THRESHOLD, 24'hffffff);
    stall_pct = 60;
    gap_max = 0;
    test_training(60);
    write_reg(REG_LEARNING_RATE, 24'($urandom));
    write_reg(REG_ERROR_THRESHOLD, 24'($urandom_range(0, 4096)));
    stall_pct = 0;
    gap_max = 10;
    test_training(90);
    write_reg(REG_LEARNING_RATE, 24'd6554);
    write_reg(REG_ERROR_THRESHOLD, 24'd17);
  endtask

  initial begin
    build_tanh_lut();
    for (int k = 0; k < 7; k++) net_w[k] = 0;
    step_rate = 6554;
    err_limit = 17;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    stall_pct = 20;
    gap_max = 4;
    test_training(180);
    test_settings();
    stall_pct = 40;
    gap_max = 3;
    test_training(60);
    drain();
    if (errors == 0) begin
      $display("mlp_1_2_1_sgd_trainer_core regression: pass");
    end else begin
      $display("mlp_1_2_1_sgd_trainer_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mlp121_pkg.sv
rtl/mlp121_mul.sv
rtl/mlp121_tanh_rom.sv
rtl/mlp121_seq.sv
rtl/mlp_1_2_1_sgd_trainer_core.sv
tb/sv/mlp_1_2_1_sgd_trainer_core_test.sv
